// File: rtl/ppmd_pkg.sv
// Package with the constants, codes and types shared by the PPM pulse-train decoder.
package ppmd_pkg;

  localparam int unsigned CHANNELS   = 12;
  localparam int unsigned WIDTH_BITS = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IDX_W      = $clog2(CHANNELS);
  localparam int unsigned CH_W       = 4;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CMP_W      = ((WIDTH_BITS > CFG_W) ? WIDTH_BITS : CFG_W) + 1;
  localparam int unsigned CNT_W      = $clog2(POS_W);

  localparam int unsigned MIN_PULSE  = 5;
  localparam int unsigned SEP_MARGIN = 7;
  localparam int unsigned JITTER     = 2;
  localparam int unsigned SLEW       = 100;
  localparam int unsigned POS_MAX    = (1 << POS_W) - 1;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SEPARATOR = cfg_idx_t'(0);
  localparam cfg_idx_t REG_TRIGGER   = cfg_idx_t'(1);
  localparam cfg_idx_t REG_MIN       = cfg_idx_t'(2);
  localparam cfg_idx_t REG_MAX       = cfg_idx_t'(3);
  localparam cfg_idx_t REG_POST      = cfg_idx_t'(4);

  localparam logic [CFG_W-1:0] SEPARATOR_RST = CFG_W'(10);
  localparam logic [CFG_W-1:0] TRIGGER_RST   = CFG_W'(200);
  localparam logic [CFG_W-1:0] MIN_RST       = CFG_W'(30);
  localparam logic [CFG_W-1:0] MAX_RST       = CFG_W'(70);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_PREP   = 5'b00100,
    S_DIV    = 5'b01000,
    S_SMOOTH = 5'b10000
  } state_e;

endpackage

// File: rtl/ppm_pulse_train_decoder.sv
// Top level of the PPM pulse-train decoder: classifier, shared divider and smoothing.
//
// Usage: each input item carries one measured pulse width and a polarity bit on
// the in_valid_i/in_ready_o channel. Each channel pulse of a synchronized frame
// yields one result item (channel_o, position_o) on out_valid_o/out_ready_i;
// short pulses, separators and sync pulses yield none.
// Registers are written on the cfg channel (cfg_valid_i/cfg_ready_o, index and data)
// by the user only while the block is idle; the block itself does not enforce this.
// cfg_ready_o is always high. Throughput: one item at a time. An item with no result
// ends after the evaluate step. A channel pulse goes on to the prepare and smoothing
// steps, and unless the scaled value is zero or clamped, to the divide step between
// them: one restoring divide stage, one quotient bit per cycle for 10 bits.
// The result sits in an output register, so the next item is taken while it waits.
// Stall: if the receiver holds out_ready_i low, a finished result stays in the
// output register; a following channel pulse waits in its last step until the
// register frees up. Reset loads the register defaults, clears sync state and
// zeroes all per-channel widths and positions at once.
module ppm_pulse_train_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [ppmd_pkg::WIDTH_BITS-1:0]  pulse_width_i,
  input  logic                             invert_polarity_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ppmd_pkg::CH_W-1:0]        channel_o,
  output logic [ppmd_pkg::POS_W-1:0]       position_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  ppmd_pkg::cfg_idx_t               cfg_index_i,
  input  logic [ppmd_pkg::CFG_W-1:0]       cfg_data_i
);
  import ppmd_pkg::*;

  state_e                 state_q, state_d;
  logic [CFG_W-1:0]       sep_q, trig_q, min_q, max_q;
  logic                   post_q;
  logic                   synced_q, synced_d;
  logic                   skip_q, skip_d;
  logic [CH_W-1:0]        idx_q, idx_d;
  logic [WIDTH_BITS-1:0]  w_q, w_d;
  logic                   inv_q, inv_d;
  logic [CFG_W-1:0]       d_q, d_d;
  logic                   degen_q, degen_d;
  logic [CFG_W-1:0]       rem_q, rem_d;
  logic [POS_W-1:0]       n_q, n_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [CH_W-1:0]        out_ch_q, out_ch_d;
  logic [POS_W-1:0]       out_pos_q, out_pos_d;

  logic [WIDTH_BITS-1:0]  last_w_q [CHANNELS];
  logic [POS_W-1:0]       smooth_q [CHANNELS];
  logic                   last_we, smooth_we;
  logic [WIDTH_BITS-1:0]  last_wdata;
  logic [POS_W-1:0]       smooth_wdata;

  logic [IDX_W-1:0]       addr;
  logic                   inverted;
  logic [CMP_W-1:0]       wc, sep_lim, trig_c, min_c, max_c, num;
  logic [WIDTH_BITS-1:0]  prev, adiff;
  logic [CFG_W:0]         shifted;
  logic                   ge;
  logic [POS_W-1:0]       s_old;
  logic signed [POS_W:0]  sdiff;
  logic [POS_W:0]         ssum;
  logic [POS_W-1:0]       s_new;
  logic [CH_W-1:0]        ch_map;
  logic                   in_range;

  assign addr     = idx_q[IDX_W-1:0];
  assign inverted = inv_q | post_q;
  assign wc       = CMP_W'(w_q);
  assign sep_lim  = CMP_W'(sep_q) + CMP_W'(SEP_MARGIN);
  assign trig_c   = CMP_W'(trig_q);
  assign min_c    = CMP_W'(min_q);
  assign max_c    = CMP_W'(max_q);
  assign in_range = {1'b0, idx_q} < (CH_W+1)'(CHANNELS);
  assign prev     = last_w_q[addr];
  assign adiff    = (prev > w_q) ? (prev - w_q) : (w_q - prev);
  assign num      = inverted ? (max_c - wc) : (wc - min_c);

  // One restoring divide step: the remainder always stays below the span.
  assign shifted  = {rem_q, 1'b0};
  assign ge       = shifted >= {1'b0, d_q};

  assign s_old    = smooth_q[addr];
  assign sdiff    = $signed({1'b0, s_old}) - $signed({1'b0, n_q});
  assign ssum     = {1'b0, s_old} + {1'b0, n_q};

  always_comb begin
    if (sdiff > $signed((POS_W+1)'(SLEW))) begin
      s_new = s_old - POS_W'(SLEW);
    end else if (sdiff < -$signed((POS_W+1)'(SLEW))) begin
      s_new = s_old + POS_W'(SLEW);
    end else begin
      s_new = ssum[POS_W:1];
    end
  end

  always_comb begin
    ch_map = idx_q;
    if (!inverted) begin
      unique case (idx_q)
        CH_W'(0): ch_map = CH_W'(1);
        CH_W'(1): ch_map = CH_W'(2);
        CH_W'(2): ch_map = CH_W'(0);
        default:  ch_map = idx_q;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign channel_o   = out_ch_q;
  assign position_o  = out_pos_q;

  always_comb begin
    state_d      = state_q;
    synced_d     = synced_q;
    skip_d       = skip_q;
    idx_d        = idx_q;
    w_d          = w_q;
    inv_d        = inv_q;
    d_d          = d_q;
    degen_d      = degen_q;
    rem_d        = rem_q;
    n_d          = n_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_ch_d     = out_ch_q;
    out_pos_d    = out_pos_q;
    last_we      = 1'b0;
    last_wdata   = w_q;
    smooth_we    = 1'b0;
    smooth_wdata = s_new;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          w_d     = pulse_width_i;
          inv_d   = invert_polarity_i;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (wc < CMP_W'(MIN_PULSE)) begin
          state_d = S_IDLE;
        end else if (wc < sep_lim || skip_q) begin
          skip_d = 1'b0;
        end else if (wc > trig_c) begin
          synced_d = 1'b1;
          skip_d   = 1'b1;
          idx_d    = '0;
        end else if (synced_q && in_range) begin
          // Small changes against the previous width of the channel are jitter.
          if (adiff < WIDTH_BITS'(JITTER)) begin
            w_d = prev;
          end
          last_we    = 1'b1;
          last_wdata = (adiff < WIDTH_BITS'(JITTER)) ? prev : w_q;
          d_d        = max_q - min_q;
          degen_d    = (max_q <= min_q);
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        if (degen_q || (inverted ? (wc >= max_c) : (wc <= min_c))) begin
          n_d     = '0;
          state_d = S_SMOOTH;
        end else if (num >= CMP_W'(d_q)) begin
          n_d     = POS_W'(POS_MAX);
          state_d = S_SMOOTH;
        end else begin
          rem_d   = num[CFG_W-1:0];
          cnt_d   = CNT_W'(POS_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = ge ? CFG_W'(shifted - {1'b0, d_q}) : shifted[CFG_W-1:0];
        n_d   = {n_q[POS_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        if (!out_valid_q || out_ready_i) begin
          smooth_we   = 1'b1;
          out_valid_d = 1'b1;
          out_ch_d    = ch_map;
          out_pos_d   = s_new;
          if (idx_q == CH_W'(CHANNELS - 1)) begin
            synced_d = 1'b0;
          end
          idx_d   = idx_q + CH_W'(1);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      synced_q    <= 1'b0;
      skip_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      sep_q       <= SEPARATOR_RST;
      trig_q      <= TRIGGER_RST;
      min_q       <= MIN_RST;
      max_q       <= MAX_RST;
      post_q      <= 1'b0;
      for (int k = 0; k < CHANNELS; k++) begin
        last_w_q[k] <= '0;
        smooth_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      synced_q    <= synced_d;
      skip_q      <= skip_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SEPARATOR: sep_q  <= cfg_data_i;
          REG_TRIGGER:   trig_q <= cfg_data_i;
          REG_MIN:       min_q  <= cfg_data_i;
          REG_MAX:       max_q  <= cfg_data_i;
          REG_POST:      post_q <= cfg_data_i[0];
          default:       ;
        endcase
      end
      if (last_we) begin
        last_w_q[addr] <= last_wdata;
      end
      if (smooth_we) begin
        smooth_q[addr] <= smooth_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    w_q       <= w_d;
    inv_q     <= inv_d;
    d_q       <= d_d;
    degen_q   <= degen_d;
    rem_q     <= rem_d;
    n_q       <= n_d;
    cnt_q     <= cnt_d;
    out_ch_q  <= out_ch_d;
    out_pos_q <= out_pos_d;
  end

`ifndef NO_ASSERTIONS
  a_div_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < d_q))
    else $error("divider remainder not below span");

  a_smooth_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SMOOTH) |-> in_range)
    else $error("channel index out of range while smoothing");

  a_result_from_smooth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_SMOOTH))
    else $error("result raised outside the smoothing step");
`endif

endmodule

// File: verif/ppm_decode_checker.sv
// Checker that predicts the decoder's channel position updates and compares them.
module ppm_decode_checker
  import ppmd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [WIDTH_BITS-1:0] pulse_width_i,
  input  logic                  invert_polarity_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic [POS_W-1:0]      position_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  cfg_idx_t              cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  output int                    mismatch_total_o,
  output int                    updates_pending_o
);

  localparam int SLEW_STEP = SLEW;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [POS_W-1:0] position;
  } joy_update_t;

  joy_update_t pending_updates[$];

  logic [CFG_W-1:0]      sep_width   = SEPARATOR_RST;
  logic [CFG_W-1:0]      trig_width  = TRIGGER_RST;
  logic [CFG_W-1:0]      min_width   = MIN_RST;
  logic [CFG_W-1:0]      max_width   = MAX_RST;
  logic                  post_on     = 1'b0;
  logic                  synced      = 1'b0;
  logic                  skip_next   = 1'b0;
  logic [CH_W-1:0]       chan_idx    = '0;
  logic [WIDTH_BITS-1:0] last_width [CHANNELS] = '{default: '0};
  logic [POS_W-1:0]      smoothed   [CHANNELS] = '{default: '0};
  int                    mismatches  = 0;

  function automatic logic [POS_W-1:0] scaled_position(input logic [WIDTH_BITS-1:0] w,
                                                       input logic inverted);
    int unsigned span, num, quot;
    if (max_width <= min_width) return '0;
    span = 32'(max_width) - 32'(min_width);
    if (inverted) begin
      if (w >= max_width) return '0;
      num = (32'(max_width) - 32'(w)) * (POS_MAX + 1);
    end else begin
      if (w <= min_width) return '0;
      num = (32'(w) - 32'(min_width)) * (POS_MAX + 1);
    end
    quot = num / span;
    return (quot > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(quot);
  endfunction

  // Advances the decoder state by one pulse; returns 1 when a position update results.
  function automatic bit decode_pulse(input logic [WIDTH_BITS-1:0] w_in, input logic inv,
                                      output joy_update_t upd);
    logic [WIDTH_BITS-1:0] w, prev, diff;
    logic                  inverted;
    logic [POS_W-1:0]      target;
    int                    idx, cur, tgt;
    w        = w_in;
    inverted = inv | post_on;
    upd      = '0;
    if (w < MIN_PULSE) return 1'b0;
    if (w < sep_width + SEP_MARGIN || skip_next) begin
      skip_next = 1'b0;
      return 1'b0;
    end
    if (w > trig_width) begin
      synced    = 1'b1;
      skip_next = 1'b1;
      chan_idx  = '0;
      return 1'b0;
    end
    if (!synced || chan_idx >= CHANNELS) return 1'b0;
    idx  = int'(chan_idx);
    prev = last_width[idx];
    diff = (prev > w) ? prev - w : w - prev;
    if (diff < JITTER) w = prev;
    last_width[idx] = w;

    target = scaled_position(w, inverted);
    cur    = int'(smoothed[idx]);
    tgt    = int'(target);
    if (cur - tgt > SLEW_STEP) cur = cur - SLEW_STEP;
    else if (tgt - cur > SLEW_STEP) cur = cur + SLEW_STEP;
    else cur = (cur + tgt) / 2;
    smoothed[idx] = POS_W'(cur);

    upd.position = POS_W'(cur);
    upd.channel  = CH_W'(idx);
    // Direct polarity rotates the first three channels.
    if (!inverted) begin
      case (idx)
        0: upd.channel = CH_W'(1);
        1: upd.channel = CH_W'(2);
        2: upd.channel = CH_W'(0);
        default: ;
      endcase
    end
    if (idx == CHANNELS - 1) synced = 1'b0;
    chan_idx = chan_idx + CH_W'(1);
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input joy_update_t want,
                               input joy_update_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected channel %0d position %0d, got channel %0d position %0d",
               $time, what, want.channel, want.position, seen.channel, seen.position);
    end
  endtask

  always @(posedge clk_i) begin : track
    joy_update_t seen, want, upd;
    bit          got_update;
    if (rst_ni) begin
      // Results are checked before new items are predicted, so the order is kept.
      if (out_valid_i && out_ready_i) begin
        seen.channel  = channel_i;
        seen.position = position_i;
        if (pending_updates.size() == 0) begin
          note_mismatch("update with none expected", '0, seen);
        end else begin
          want = pending_updates.pop_front();
          if (seen.channel !== want.channel || seen.position !== want.position) begin
            note_mismatch("update differs", want, seen);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SEPARATOR: sep_width  = cfg_data_i;
          REG_TRIGGER:   trig_width = cfg_data_i;
          REG_MIN:       min_width  = cfg_data_i;
          REG_MAX:       max_width  = cfg_data_i;
          REG_POST:      post_on    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        got_update = decode_pulse(pulse_width_i, invert_polarity_i, upd);
        if (got_update) pending_updates.push_back(upd);
      end
    end
    mismatch_total_o  <= mismatches;
    updates_pending_o <= pending_updates.size();
  end

endmodule

// File: verif/testbench.sv
// Testbench top for the PPM pulse-train decoder: stimulus, output pacing and verdict.
module testbench;
  import ppmd_pkg::*;

  localparam int LIMIT_CYCLES  = 600000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int WIDTH_TOP     = (1 << WIDTH_BITS) - 1;
  localparam cfg_idx_t REG_SPARE = cfg_idx_t'(7);

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [WIDTH_BITS-1:0] pulse_width;
  logic                  invert;
  logic                  out_valid;
  logic                  out_ready;
  logic [CH_W-1:0]       channel;
  logic [POS_W-1:0]      position;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  int mismatch_total;
  int updates_pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  int gap_next    = 0;
  bit valid_up    = 1'b0;
  bit hold_req    = 1'b0;
  bit hold_done   = 1'b0;
  int cur_sep     = 10;
  int cur_trig    = 200;
  int cur_min     = 30;
  int cur_max     = 70;
  int last_sent [CHANNELS] = '{default: 0};

  // Short pulses, separators, an unsynced channel, sync with the skipped pulse after it,
  // clamping at both ends, inverted polarity and jitter against the previous frame.
  int directed_width [22] = '{0, 4, 5, 16, 17, 201, 4, 100, 70, 71, 16, 50, 29, 200,
                              WIDTH_TOP, 5, 71, 68, 49, 35, 45, 55};
  bit directed_invert [22] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0,
                               0, 0, 0, 1, 0, 0, 0, 0};

  ppm_pulse_train_decoder dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .pulse_width_i     (pulse_width),
    .invert_polarity_i (invert),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .channel_o         (channel),
    .position_o        (position),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  ppm_decode_checker decode_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .pulse_width_i     (pulse_width),
    .invert_polarity_i (invert),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .channel_i         (channel),
    .position_i        (position),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .mismatch_total_o  (mismatch_total),
    .updates_pending_o (updates_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic int pick(input int lo, input int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int fit(input int v);
    return (v > WIDTH_TOP) ? WIDTH_TOP : ((v < 0) ? 0 : v);
  endfunction

  function automatic int noise_width();
    case ($urandom_range(4, 0))
      0, 1:    return int'($urandom_range(WIDTH_TOP, 0));
      2:       return int'($urandom_range(MIN_PULSE + 5, 0));
      3:       return int'($urandom & WIDTH_TOP);
      default: return pick(0, 400);
    endcase
  endfunction

  function automatic int sync_width();
    if (cur_trig >= WIDTH_TOP) return noise_width();
    if ($urandom_range(4, 0) != 0) return pick(cur_trig + 1, fit(cur_trig + 400));
    return pick(cur_trig + 1, WIDTH_TOP);
  endfunction

  function automatic int separator_pick();
    return pick(MIN_PULSE, fit(cur_sep + int'(SEP_MARGIN) - 1));
  endfunction

  // Channel pulses mostly land near the scaling span; some repeat the last width of
  // the channel within a couple of counts to exercise the jitter filter.
  function automatic int channel_width(input int ch);
    int lo, hi, a, b, w;
    lo = cur_sep + int'(SEP_MARGIN);
    hi = cur_trig;
    if (lo > hi) return noise_width();
    a = (cur_min - 8 > lo) ? cur_min - 8 : lo;
    b = (cur_max + 8 < hi) ? cur_max + 8 : hi;
    case ($urandom_range(9, 0))
      0, 1, 2: w = last_sent[ch] + int'($urandom_range(4, 0)) - 2;
      3, 4, 5, 6, 7: w = (a > b) ? pick(lo, hi) : pick(a, b);
      default: w = pick(lo, hi);
    endcase
    if (w < lo) w = lo;
    if (w > hi) w = hi;
    last_sent[ch] = w;
    return w;
  endfunction

  task automatic send_pulse(input int w, input logic inv);
    if (!valid_up) begin
      repeat (gap_next) @(posedge clk);
      gap_next = 0;
    end
    in_valid    <= 1'b1;
    pulse_width <= WIDTH_BITS'(w);
    invert      <= inv;
    valid_up     = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (w >= MIN_PULSE) items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(3, 0) == 0) begin
        burst_left = $urandom_range(200, 60);
        gap_next   = 0;
      end else begin
        burst_left = $urandom_range(12, 1);
        gap_next   = ($urandom_range(4, 0) == 0) ? $urandom_range(20, 4) : $urandom_range(3, 0);
      end
      if (gap_next > 0) begin
        in_valid <= 1'b0;
        valid_up  = 1'b0;
      end
    end
  endtask

  task automatic drain();
    if (valid_up) begin
      in_valid <= 1'b0;
      valid_up  = 1'b0;
    end
    @(posedge clk);
    while (updates_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic send_frame(input bit broken);
    int  ch, cut;
    logic inv;
    inv = 1'($urandom_range(1, 0));
    // Whole frames sometimes run past the last channel, after sync has dropped.
    if (broken) cut = $urandom_range(CHANNELS, 0);
    else cut = CHANNELS + (($urandom_range(3, 0) == 0) ? 2 : 0);
    send_pulse(sync_width(), inv);
    send_pulse(separator_pick(), inv);
    for (ch = 0; ch < cut; ch++) begin
      if ($urandom_range(9, 0) != 0) send_pulse(separator_pick(), inv);
      if (broken && $urandom_range(7, 0) == 0) begin
        send_pulse(noise_width(), 1'($urandom_range(1, 0)));
      end
      send_pulse(channel_width(ch % CHANNELS), ($urandom_range(15, 0) == 0) ? ~inv : inv);
    end
  endtask

  task automatic run_phase(input int sep, input int trig, input int lo_width,
                           input int hi_width, input int post, input int count,
                           input bit stress);
    int first, r, n, k;
    bit paused;
    drain();
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_MIN, lo_width);
    write_reg(REG_MAX, hi_width);
    write_reg(REG_POST, (int'($urandom_range(WIDTH_TOP, 0)) & ~1) | post);
    if (stress) write_reg(REG_SPARE, $urandom_range(WIDTH_TOP, 0));
    cfg_valid <= 1'b0;
    cur_sep  = sep;
    cur_trig = trig;
    cur_min  = lo_width;
    cur_max  = hi_width;
    first    = items_sent;
    paused   = 1'b0;
    while (items_sent - first < count) begin
      r = $urandom_range(99, 0);
      if (r < 75) begin
        send_frame(1'b0);
      end else if (r < 88) begin
        send_frame(1'b1);
      end else begin
        n = $urandom_range(6, 1);
        for (k = 0; k < n; k++) send_pulse(noise_width(), 1'($urandom_range(1, 0)));
      end
      if (stress && items_sent - first > count / 3) hold_req = 1'b1;
      if (stress && !paused && items_sent - first > 2 * count / 3) begin
        drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin : receiver
    int span, mode, k;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      mode = $urandom_range(3, 0);
      span = (mode == 3) ? $urandom_range(30, 1) : $urandom_range(200, 10);
      for (k = 0; k < span; k++) begin
        if (hold_req && !hold_done) begin
          // The output register stays full long enough for the input side to back up.
          out_ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(1, 0));
          2:       out_ready <= ($urandom_range(3, 0) == 0);
          default: out_ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int k;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    pulse_width <= '0;
    invert      <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= REG_SEPARATOR;
    cfg_data    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (k = 0; k < 22; k++) send_pulse(directed_width[k], directed_invert[k]);

    run_phase(10, 200, 30, 70, 0, 350, 1'b1);
    run_phase(10, 200, 30, 70, 1, 250, 1'b0);
    run_phase(0, WIDTH_TOP - 1, 0, WIDTH_TOP, 0, 300, 1'b0);
    // Everything is a separator here, and the span is inverted.
    run_phase(WIDTH_TOP, WIDTH_TOP, WIDTH_TOP, 1, 1, 40, 1'b0);
    // Every pulse that is not a separator is taken as sync.
    run_phase(5, 0, 10, 20, 0, 40, 1'b0);
    run_phase(20, 1000, 100, 100, 0, 200, 1'b0);
    run_phase(3, 300, 50, 51, 1, 200, 1'b0);
    run_phase(12, 5000, 1000, 4000, 0, 300, 1'b0);
    run_phase(10, 200, 30, 70, 0, 270, 1'b1);

    drain();
    if (mismatch_total == 0 && updates_pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
